FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("invariant violated");
`define ASSERT_SEQ(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("sequence check failed");
`else
`define ASSERT_HOLDS(lbl, clk, rstn, expr)
`define ASSERT_SEQ(lbl, clk, rstn, prop)
`endif
`endif

FILE: src/ple_pkg.sv
// Shared types and codes of the positional list engine
package ple_pkg;

    localparam int REQ_W    = 3;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REM_BACK  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REM_POS   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_LIST      = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESP,
        S_LIST
    } ple_state_t;

    typedef struct packed {
        logic exec;
        logic rotate;
        logic list_mode;
    } ple_cmd_t;

    typedef struct packed {
        logic list_go;
        logic list_last;
    } ple_sts_t;

endpackage

FILE: src/ple_datapath.sv
// Element cells, count, status and list walk of the positional list engine
module ple_datapath #(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [ple_pkg::REQ_W-1:0]             s_req_type,
    input  logic signed [ple_pkg::VAL_W-1:0]      s_value,
    input  logic [ple_pkg::POS_W-1:0]             s_position,
    input  ple_pkg::ple_cmd_t                     cmd,
    output ple_pkg::ple_sts_t                     sts,
    output logic [ple_pkg::STATUS_W-1:0]          m_status,
    output logic [CNT_W-1:0]                      m_element_count,
    output logic signed [ple_pkg::VAL_W-1:0]      m_read_value,
    output logic                                  m_last
);

    localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;

    logic [ple_pkg::VAL_W-1:0]    cell_reg [DEPTH];
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [ple_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]             list_idx_reg, list_idx_next;

    logic             do_ins, do_rem;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] last_idx;
    logic [CMP_W-1:0] pos_ext, cnt_ext;
    logic             full, empty;

    assign pos_ext  = CMP_W'(s_position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    always_comb begin
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        k           = '0;
        status_next = ple_pkg::ST_OK;
        count_next  = count_reg;
        unique case (s_req_type) inside
            ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_BACK, ple_pkg::REQ_INS_POS: begin
                if (full) begin
                    status_next = ple_pkg::ST_FULL;
                end else if (s_req_type == ple_pkg::REQ_INS_FRONT) begin
                    do_ins = 1'b1;
                end else if (s_req_type == ple_pkg::REQ_INS_BACK) begin
                    do_ins = 1'b1;
                    k      = IDX_W'(count_reg);
                end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                    status_next = ple_pkg::ST_BADPOS;
                end else begin
                    do_ins = 1'b1;
                    k      = IDX_W'(pos_ext - CMP_W'(1));
                end
                if (do_ins) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ple_pkg::REQ_REM_FRONT, ple_pkg::REQ_REM_BACK, ple_pkg::REQ_REM_POS: begin
                if (empty) begin
                    status_next = ple_pkg::ST_EMPTY;
                end else if (s_req_type == ple_pkg::REQ_REM_FRONT) begin
                    do_rem = 1'b1;
                end else if (s_req_type == ple_pkg::REQ_REM_BACK) begin
                    do_rem = 1'b1;
                    k      = last_idx;
                end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                    status_next = ple_pkg::ST_BADPOS;
                end else begin
                    do_rem = 1'b1;
                    k      = IDX_W'(pos_ext - CMP_W'(1));
                end
                if (do_rem) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ple_pkg::REQ_LIST: begin
                status_next = empty ? ple_pkg::ST_EMPTY : ple_pkg::ST_OK;
            end
            default: begin
                status_next = ple_pkg::ST_OK;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [ple_pkg::VAL_W-1:0] prev_val, next_val;
            if (gi == 0) begin : g_first
                assign prev_val = cell_reg[0];
            end else begin : g_mid
                assign prev_val = cell_reg[gi-1];
            end
            if (gi == DEPTH-1) begin : g_end
                assign next_val = cell_reg[gi];
            end else begin : g_inner
                assign next_val = cell_reg[gi+1];
            end

            always_ff @(posedge aclk) begin
                if (cmd.exec && do_ins) begin
                    if (IDX_W'(gi) > k) begin
                        cell_reg[gi] <= prev_val;
                    end else if (IDX_W'(gi) == k) begin
                        cell_reg[gi] <= s_value;
                    end
                end else if (cmd.exec && do_rem) begin
                    if (IDX_W'(gi) >= k) begin
                        cell_reg[gi] <= next_val;
                    end
                end else if (cmd.rotate) begin
                    if (IDX_W'(gi) < last_idx) begin
                        cell_reg[gi] <= next_val;
                    end else if (IDX_W'(gi) == last_idx) begin
                        cell_reg[gi] <= cell_reg[0];
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        list_idx_next = list_idx_reg;
        if (cmd.exec) begin
            list_idx_next = '0;
        end else if (cmd.rotate) begin
            list_idx_next = list_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            list_idx_reg <= '0;
        end else begin
            list_idx_reg <= list_idx_next;
            if (cmd.exec) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
        end
    end

    assign sts.list_go   = (s_req_type == ple_pkg::REQ_LIST) && !empty;
    assign sts.list_last = (list_idx_reg == last_idx);

    assign m_status        = cmd.list_mode ? ple_pkg::ST_OK : status_reg;
    assign m_element_count = count_reg;
    assign m_read_value    = cmd.list_mode ? cell_reg[0] : '0;
    assign m_last          = cmd.list_mode ? sts.list_last : 1'b1;

endmodule

FILE: src/ple_ctrl.sv
// Request sequencer of the positional list engine
module ple_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  ple_pkg::ple_sts_t  sts,
    output ple_pkg::ple_cmd_t  cmd
);

    ple_pkg::ple_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ple_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = sts.list_go ? ple_pkg::S_LIST : ple_pkg::S_RESP;
                end
            end
            ple_pkg::S_RESP: begin
                if (m_ready) begin
                    state_next = ple_pkg::S_IDLE;
                end
            end
            ple_pkg::S_LIST: begin
                if (m_ready && sts.list_last) begin
                    state_next = ple_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd.exec      = 1'b0;
        cmd.rotate    = 1'b0;
        cmd.list_mode = 1'b0;
        unique case (state_reg)
            ple_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.exec = s_valid;
            end
            ple_pkg::S_RESP: begin
                m_valid = 1'b1;
            end
            ple_pkg::S_LIST: begin
                m_valid       = 1'b1;
                cmd.list_mode = 1'b1;
                cmd.rotate    = m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ple_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/positional_list_engine_unit.sv
// Top level of the positional list engine
//
//   channel  | ports             | beat
//   request  | s_valid / s_ready | req_type, value, position
//   result   | m_valid / m_ready | status, element_count, read_value, last
//
// An edit is accepted, then answered with one result beat; all cells shift at once.
// A non-empty list gives one beat per element: the first count cells rotate one place per beat.
// Reset clears the count and the sequencer; cell contents are not cleared.
// A stalled result holds its beat; no request is taken until the last beat leaves.
`include "assert_macros.svh"

module positional_list_engine_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_valid,
    output logic                                          s_ready,
    input  logic [ple_pkg::REQ_W-1:0]                     s_req_type,
    input  logic signed [ple_pkg::VAL_W-1:0]              s_value,
    input  logic [ple_pkg::POS_W-1:0]                     s_position,
    output logic                                          m_valid,
    input  logic                                          m_ready,
    output logic [ple_pkg::STATUS_W-1:0]                  m_status,
    output logic [$clog2(DEPTH+1)-1:0]                    m_element_count,
    output logic signed [ple_pkg::VAL_W-1:0]              m_read_value,
    output logic                                          m_last
);

    localparam int CNT_W = $clog2(DEPTH+1);

    ple_pkg::ple_cmd_t cmd;
    ple_pkg::ple_sts_t sts;

    ple_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ple_datapath #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_req_type      (s_req_type),
        .s_value         (s_value),
        .s_position      (s_position),
        .cmd             (cmd),
        .sts             (sts),
        .m_status        (m_status),
        .m_element_count (m_element_count),
        .m_read_value    (m_read_value),
        .m_last          (m_last)
    );

    `ASSERT_HOLDS(a_count_bound, aclk, aresetn, m_element_count <= CNT_W'(DEPTH))
    `ASSERT_HOLDS(a_one_side, aclk, aresetn, !(s_ready && m_valid))
    `ASSERT_SEQ(a_accept_answers, aclk, aresetn, (s_valid && s_ready) |=> m_valid)
    `ASSERT_SEQ(a_count_quiet, aclk, aresetn, !(s_valid && s_ready) |=> $stable(m_element_count))

endmodule

FILE: tb/ple_list_checker.sv
// Checker for the positional list engine: predicts each request's beats and compares them
`timescale 1ns / 1ps

module ple_list_checker #(
    parameter int DEPTH = 16,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic [ple_pkg::REQ_W-1:0]             s_req_type,
    input  logic signed [ple_pkg::VAL_W-1:0]      s_value,
    input  logic [ple_pkg::POS_W-1:0]             s_position,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [ple_pkg::STATUS_W-1:0]          m_status,
    input  logic [CNT_W-1:0]                      m_element_count,
    input  logic signed [ple_pkg::VAL_W-1:0]      m_read_value,
    input  logic                                  m_last,
    output int                                    fail_count,
    output int                                    pending_beats
);

    typedef struct packed {
        logic [ple_pkg::STATUS_W-1:0]        status;
        logic [CNT_W-1:0]                    count;
        logic signed [ple_pkg::VAL_W-1:0]    value;
        logic                                last;
    } list_beat_t;

    logic signed [ple_pkg::VAL_W-1:0] cells [DEPTH];
    int cell_count = 0;
    int mismatches = 0;
    list_beat_t expected_beats [$];

    task automatic queue_beat(input logic [ple_pkg::STATUS_W-1:0] st,
                              input logic signed [ple_pkg::VAL_W-1:0] val,
                              input logic fin);
        list_beat_t b;
        b.status = st;
        b.count  = CNT_W'(cell_count);
        b.value  = val;
        b.last   = fin;
        expected_beats.push_back(b);
    endtask

    task automatic insert_cell(input int idx, input logic signed [ple_pkg::VAL_W-1:0] val);
        int i;
        for (i = cell_count; i > idx; i--)
            cells[i] = cells[i - 1];
        cells[idx] = val;
        cell_count++;
    endtask

    task automatic remove_cell(input int idx);
        int i;
        for (i = idx; i + 1 < cell_count; i++)
            cells[i] = cells[i + 1];
        cell_count--;
    endtask

    task automatic apply_request(input logic [ple_pkg::REQ_W-1:0] req,
                                 input logic signed [ple_pkg::VAL_W-1:0] val,
                                 input logic [ple_pkg::POS_W-1:0] pos);
        logic [ple_pkg::STATUS_W-1:0] st;
        int i;
        st = ple_pkg::ST_OK;
        if (req == ple_pkg::REQ_LIST) begin
            if (cell_count == 0) begin
                queue_beat(ple_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
                for (i = 0; i < cell_count; i++)
                    queue_beat(ple_pkg::ST_OK, cells[i], i + 1 == cell_count);
            end
        end else begin
            case (req)
                ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_BACK, ple_pkg::REQ_INS_POS: begin
                    if (cell_count >= DEPTH)
                        st = ple_pkg::ST_FULL;
                    else if (req == ple_pkg::REQ_INS_FRONT)
                        insert_cell(0, val);
                    else if (req == ple_pkg::REQ_INS_BACK)
                        insert_cell(cell_count, val);
                    else if (pos < 1 || pos > cell_count + 1)
                        st = ple_pkg::ST_BADPOS;
                    else
                        insert_cell(pos - 1, val);
                end
                ple_pkg::REQ_REM_FRONT, ple_pkg::REQ_REM_BACK, ple_pkg::REQ_REM_POS: begin
                    if (cell_count == 0)
                        st = ple_pkg::ST_EMPTY;
                    else if (req == ple_pkg::REQ_REM_FRONT)
                        remove_cell(0);
                    else if (req == ple_pkg::REQ_REM_BACK)
                        remove_cell(cell_count - 1);
                    else if (pos < 1 || pos > cell_count)
                        st = ple_pkg::ST_BADPOS;
                    else
                        remove_cell(pos - 1);
                end
                default: ;
            endcase
            queue_beat(st, '0, 1'b1);
        end
    endtask

    task automatic compare_beat();
        list_beat_t want;
        if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat status=%0d count=%0d value=%0d last=%0d",
                     $time, m_status, m_element_count, m_read_value, m_last);
            mismatches++;
        end else begin
            want = expected_beats.pop_front();
            if (m_status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, m_status);
                mismatches++;
            end
            if (m_element_count !== want.count) begin
                $display("%0t: element_count expected %0d got %0d",
                         $time, want.count, m_element_count);
                mismatches++;
            end
            if (m_read_value !== want.value) begin
                $display("%0t: read_value expected %0d got %0d",
                         $time, want.value, m_read_value);
                mismatches++;
            end
            if (m_last !== want.last) begin
                $display("%0t: last expected %0d got %0d", $time, want.last, m_last);
                mismatches++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cell_count = 0;
            expected_beats.delete();
        end else begin
            if (m_valid && m_ready)
                compare_beat();
            if (s_valid && s_ready)
                apply_request(s_req_type, s_value, s_position);
        end
        fail_count    <= mismatches;
        pending_beats <= expected_beats.size();
    end

endmodule

FILE: tb/tb.sv
// Testbench top: drives requests into the positional list engine and reports the verdict
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH          = 16;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS   = 250;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [ple_pkg::REQ_W-1:0] REQ_RESERVED = 3'd7;

    logic                                aclk;
    logic                                aresetn    = 1'b0;
    logic                                s_valid    = 1'b0;
    logic                                s_ready;
    logic [ple_pkg::REQ_W-1:0]           s_req_type = '0;
    logic signed [ple_pkg::VAL_W-1:0]    s_value    = '0;
    logic [ple_pkg::POS_W-1:0]           s_position = '0;
    logic                                m_valid;
    logic                                m_ready    = 1'b0;
    logic [ple_pkg::STATUS_W-1:0]        m_status;
    logic [CNT_W-1:0]                    m_element_count;
    logic signed [ple_pkg::VAL_W-1:0]    m_read_value;
    logic                                m_last;

    int fail_count;
    int pending_beats;
    int rx_cycle = 0;
    int rx_hold  = 0;
    int quiet_cycles = 0;
    bit no_idle = 1'b0;

    positional_list_engine_unit #(.DEPTH(DEPTH)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_value         (s_value),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_element_count (m_element_count),
        .m_read_value    (m_read_value),
        .m_last          (m_last)
    );

    ple_list_checker #(.DEPTH(DEPTH)) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_value         (s_value),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_element_count (m_element_count),
        .m_read_value    (m_read_value),
        .m_last          (m_last),
        .fail_count      (fail_count),
        .pending_beats   (pending_beats)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [ple_pkg::VAL_W-1:0] rand_value();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ple_pkg::POS_W-1:0] rand_position();
        if ($urandom_range(0, 9) == 0)
            return ple_pkg::POS_W'($urandom_range(0, 31));
        return ple_pkg::POS_W'($urandom_range(1, DEPTH + 1));
    endfunction

    // phase 0 grows the list, phase 1 is balanced, phase 2 shrinks it
    function automatic logic [ple_pkg::REQ_W-1:0] pick_request(input int phase);
        int r;
        int lim [7];
        r = $urandom_range(0, 99);
        case (phase)
            0: lim = '{25, 50, 80, 85, 89, 92, 98};
            1: lim = '{12, 24, 40, 52, 64, 82, 97};
            default: lim = '{5, 10, 18, 38, 58, 88, 98};
        endcase
        if (r < lim[0]) return ple_pkg::REQ_INS_FRONT;
        if (r < lim[1]) return ple_pkg::REQ_INS_BACK;
        if (r < lim[2]) return ple_pkg::REQ_INS_POS;
        if (r < lim[3]) return ple_pkg::REQ_REM_FRONT;
        if (r < lim[4]) return ple_pkg::REQ_REM_BACK;
        if (r < lim[5]) return ple_pkg::REQ_REM_POS;
        if (r < lim[6]) return ple_pkg::REQ_LIST;
        return REQ_RESERVED;
    endfunction

    task automatic offer(input logic [ple_pkg::REQ_W-1:0] req,
                         input logic signed [ple_pkg::VAL_W-1:0] val,
                         input logic [ple_pkg::POS_W-1:0] pos);
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_value    <= val;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_after(input int gap, input bit drain);
        if (gap > 0 || drain)
            s_valid <= 1'b0;
        repeat (gap) @(posedge aclk);
        if (drain) begin
            @(posedge aclk);
            while (pending_beats != 0) @(posedge aclk);
        end
    endtask

    task automatic issue(input logic [ple_pkg::REQ_W-1:0] req,
                         input logic signed [ple_pkg::VAL_W-1:0] val,
                         input logic [ple_pkg::POS_W-1:0] pos);
        offer(req, val, pos);
        pause_after(no_idle ? 0 : idle_gap(), 1'b0);
    endtask

    // receiver: random stalls, a long hold-off, and periodic always-ready windows
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle >= 500 && rx_cycle < 800) begin
            m_ready <= 1'b0;
        end else if (rx_cycle % 1000 < 150) begin
            m_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_hold <= idle_gap();
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("positional_list_engine_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        issue(ple_pkg::REQ_LIST,      32'h0000_0000, 5'd0);
        issue(ple_pkg::REQ_REM_FRONT, 32'h1234_5678, 5'd0);
        issue(ple_pkg::REQ_REM_BACK,  32'h0000_0000, 5'd31);
        issue(ple_pkg::REQ_REM_POS,   32'h0000_0000, 5'd1);
        issue(ple_pkg::REQ_INS_POS,   32'h0000_0011, 5'd0);
        issue(ple_pkg::REQ_INS_POS,   32'h0000_0022, 5'd2);
        issue(ple_pkg::REQ_INS_FRONT, 32'h7FFF_FFFF, 5'd0);
        issue(ple_pkg::REQ_INS_BACK,  32'h8000_0000, 5'd0);
        issue(ple_pkg::REQ_INS_POS,   32'hFFFF_FFFF, 5'd2);
        issue(ple_pkg::REQ_INS_POS,   32'h0000_0000, 5'd4);
        issue(ple_pkg::REQ_INS_POS,   32'h0000_3039, 5'd1);
        issue(ple_pkg::REQ_INS_POS,   32'h5555_AAAA, 5'd31);
        issue(ple_pkg::REQ_INS_POS,   32'hAAAA_5555, 5'd16);
        issue(ple_pkg::REQ_LIST,      32'hFFFF_FFFF, 5'd31);
        issue(ple_pkg::REQ_REM_POS,   32'h0000_0000, 5'd0);
        issue(ple_pkg::REQ_REM_POS,   32'h0000_0000, 5'd6);
        issue(ple_pkg::REQ_REM_POS,   32'h0000_0000, 5'd5);
        issue(ple_pkg::REQ_REM_POS,   32'h0000_0000, 5'd2);
        issue(REQ_RESERVED,           32'hDEAD_BEEF, 5'd17);
        issue(ple_pkg::REQ_LIST,      32'h0000_0000, 5'd0);
        issue(ple_pkg::REQ_REM_FRONT, 32'h0000_0000, 5'd0);
        issue(ple_pkg::REQ_REM_BACK,  32'h0000_0000, 5'd0);
        issue(ple_pkg::REQ_LIST,      32'h0000_0000, 5'd0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 60 && n < 100);
            offer(pick_request((n / 45) % 3), rand_value(), rand_position());
            pause_after(no_idle ? 0 : idle_gap(), n == 150 || n == RANDOM_ITEMS - 1);
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("positional_list_engine_unit verification clean");
        else
            $display("positional_list_engine_unit verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/ple_pkg.sv
src/ple_datapath.sv
src/ple_ctrl.sv
src/positional_list_engine_unit.sv
tb/ple_list_checker.sv
tb/tb.sv
